FILE: rtl/csb_pkg.sv
// ----------------------------------------------------------------------------
// csb_pkg
// Shared types and constants for the clipped sprite blitter.
// ----------------------------------------------------------------------------
package csb_pkg;

	localparam int SCREEN_WIDTH  = 320;
	localparam int SCREEN_HEIGHT = 200;

	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;
	localparam int COUNT_W    = 16;
	localparam int COORD_W    = COUNT_W + 2;
	localparam int ADDR_W     = 16;
	localparam int PIXEL_W    = 8;

	localparam logic [PIXEL_W-1:0] KEY_PIXEL = '1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEST_X        = 3'd0,
		REG_DEST_Y        = 3'd1,
		REG_SPRITE_WIDTH  = 3'd2,
		REG_SPRITE_HEIGHT = 3'd3,
		REG_KEY_ENABLE    = 3'd4
	} cfg_reg_t;

	// Screen position of one sprite pixel, handed from the raster counters
	// to the write stage.
	typedef struct packed {
		logic                      active;
		logic                      last;
		logic signed [COORD_W-1:0] sx;
		logic signed [COORD_W-1:0] sy;
		logic [PIXEL_W-1:0]        pixel;
	} coord_t;

endpackage

FILE: rtl/csb_raster.sv
// ----------------------------------------------------------------------------
// csb_raster
// Column and row counters that follow the sprite pixel position, and the
// screen coordinates of the pixel at the head of the input channel.
// ----------------------------------------------------------------------------
module csb_raster (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                advance,
	input  logic                                clear,
	input  logic [csb_pkg::CFG_DATA_W-1:0]      dest_x,
	input  logic [csb_pkg::CFG_DATA_W-1:0]      dest_y,
	input  logic [csb_pkg::COUNT_W-1:0]         sprite_width,
	input  logic [csb_pkg::COUNT_W-1:0]         sprite_height,
	input  logic [csb_pkg::PIXEL_W-1:0]         source_pixel,
	output csb_pkg::coord_t                     coord
);

	logic [csb_pkg::COUNT_W-1:0] col_q;
	logic [csb_pkg::COUNT_W-1:0] row_q;
	logic                        active;
	logic                        row_end;
	logic                        col_end;

	assign active  = (sprite_width != '0) && (sprite_height != '0);
	assign row_end = ({1'b0, col_q} + (csb_pkg::COUNT_W+1)'(1)) >= {1'b0, sprite_width};
	assign col_end = ({1'b0, row_q} + (csb_pkg::COUNT_W+1)'(1)) >= {1'b0, sprite_height};

	always_comb begin
		coord.active = active;
		coord.last   = active && row_end && col_end;
		coord.sx     = $signed({{2{dest_x[csb_pkg::CFG_DATA_W-1]}}, dest_x})
			+ $signed({2'b00, col_q});
		coord.sy     = $signed({{2{dest_y[csb_pkg::CFG_DATA_W-1]}}, dest_y})
			+ $signed({2'b00, row_q});
		coord.pixel  = source_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (clear) begin
			col_q <= '0;
			row_q <= '0;
		end else if (advance) begin
			if (!active) begin
				col_q <= '0;
				row_q <= '0;
			end else if (row_end) begin
				col_q <= '0;
				row_q <= col_end ? '0 : row_q + 1'b1;
			end else begin
				col_q <= col_q + 1'b1;
			end
		end
	end

	// The counters never pass the sprite bounds.
	a_col_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(sprite_width != '0) |-> (col_q < sprite_width))
		else $error("column counter beyond sprite width");

	a_row_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(sprite_height != '0) |-> (row_q < sprite_height))
		else $error("row counter beyond sprite height");

endmodule

FILE: rtl/csb_write_stage.sv
// ----------------------------------------------------------------------------
// csb_write_stage
// Input register, clipping, color key and address math, and the result
// register with its handshake.
// ----------------------------------------------------------------------------
module csb_write_stage (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_ready,
	input  csb_pkg::coord_t                coord,
	input  logic                           key_enable,
	output logic                           out_valid,
	input  logic                           out_ready,
	output logic                           write_enable,
	output logic [csb_pkg::ADDR_W-1:0]     write_address,
	output logic [csb_pkg::PIXEL_W-1:0]    write_data,
	output logic                           end_of_sprite
);

	localparam logic [csb_pkg::COORD_W-2:0] SW = (csb_pkg::COORD_W-1)'(csb_pkg::SCREEN_WIDTH);
	localparam logic [csb_pkg::COORD_W-2:0] SH = (csb_pkg::COORD_W-1)'(csb_pkg::SCREEN_HEIGHT);
	localparam logic [csb_pkg::ADDR_W-1:0]  SW_A = csb_pkg::ADDR_W'(csb_pkg::SCREEN_WIDTH);

	csb_pkg::coord_t             coord_s1;
	logic                        valid_s1;
	logic                        s1_load;
	logic                        s2_load;
	logic                        on_screen;
	logic                        transparent;
	logic                        we;
	logic [csb_pkg::ADDR_W-1:0]  addr;

	assign s2_load  = !out_valid || out_ready;
	assign s1_load  = !valid_s1 || s2_load;
	assign in_ready = s1_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s1_load) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_load && in_valid) begin
			coord_s1 <= coord;
		end
	end

	always_comb begin
		on_screen = !coord_s1.sx[csb_pkg::COORD_W-1]
			&& (coord_s1.sx[csb_pkg::COORD_W-2:0] < SW)
			&& !coord_s1.sy[csb_pkg::COORD_W-1]
			&& (coord_s1.sy[csb_pkg::COORD_W-2:0] < SH);
		transparent = key_enable && (coord_s1.pixel == csb_pkg::KEY_PIXEL);
		we   = coord_s1.active && on_screen && !transparent;
		// Only the low address bits are kept, so the product is taken mod 2^16.
		addr = coord_s1.sx[csb_pkg::ADDR_W-1:0]
			+ coord_s1.sy[csb_pkg::ADDR_W-1:0] * SW_A;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (s2_load) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (s2_load && valid_s1) begin
			write_enable  <= we;
			write_address <= we ? addr : '0;
			write_data    <= we ? coord_s1.pixel : '0;
			end_of_sprite <= coord_s1.last;
		end
	end

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !write_enable) |-> (write_address == '0 && write_data == '0))
		else $error("data or address set on an item without a write");

	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !s2_load) |=> (valid_s1 && $stable(coord_s1)))
		else $error("input register lost an item during a stall");

	a_full_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && out_valid && !out_ready) |-> !in_ready)
		else $error("item accepted while both registers are full and stalled");

endmodule

FILE: rtl/clipped_sprite_blit.sv
// ----------------------------------------------------------------------------
// clipped_sprite_blit
// Clipped, optionally color-keyed sprite blit: one framebuffer write
// candidate for each sprite pixel.
// ----------------------------------------------------------------------------
// Usage: sprite pixels enter in raster order on source_pixel with
// in_valid/in_ready, one result item leaves on out_valid/out_ready for
// every pixel. The result carries write_enable, write_address
// (column + SCREEN_WIDTH * row), write_data and end_of_sprite.
// Registers dest_x, dest_y, sprite_width, sprite_height and key_enable are
// written through cfg_we/cfg_index/cfg_data; the user must write them only
// while the block is idle, and the block itself does not enforce this; any
// write to a known register restarts the sprite at its first pixel.
// An accepted item sits in the input register, then moves to the result
// register, which drives the outputs. Throughput is one item per cycle while
// the receiver does not stall, set by the input and result registers.
// When the receiver holds out_ready low, the result register holds, the
// input register fills, and then in_ready drops until the result is taken.
// Reset clears the config registers, pixel counters and valid flags, not data.
// ----------------------------------------------------------------------------
module clipped_sprite_blit (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_we,
	input  logic [csb_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [csb_pkg::CFG_DATA_W-1:0]      cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [csb_pkg::PIXEL_W-1:0]         source_pixel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                write_enable,
	output logic [csb_pkg::ADDR_W-1:0]          write_address,
	output logic [csb_pkg::PIXEL_W-1:0]         write_data,
	output logic                                end_of_sprite
);

	logic [csb_pkg::CFG_DATA_W-1:0] dest_x_q;
	logic [csb_pkg::CFG_DATA_W-1:0] dest_y_q;
	logic [csb_pkg::COUNT_W-1:0]    sprite_width_q;
	logic [csb_pkg::COUNT_W-1:0]    sprite_height_q;
	logic                           key_enable_q;
	logic                           cfg_hit;
	csb_pkg::coord_t                coord;

	always_comb begin
		unique case (cfg_index)
			csb_pkg::REG_DEST_X, csb_pkg::REG_DEST_Y, csb_pkg::REG_SPRITE_WIDTH,
			csb_pkg::REG_SPRITE_HEIGHT, csb_pkg::REG_KEY_ENABLE: cfg_hit = cfg_we;
			default: cfg_hit = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dest_x_q        <= '0;
			dest_y_q        <= '0;
			sprite_width_q  <= '0;
			sprite_height_q <= '0;
			key_enable_q    <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				csb_pkg::REG_DEST_X:        dest_x_q        <= cfg_data;
				csb_pkg::REG_DEST_Y:        dest_y_q        <= cfg_data;
				csb_pkg::REG_SPRITE_WIDTH:  sprite_width_q  <= cfg_data;
				csb_pkg::REG_SPRITE_HEIGHT: sprite_height_q <= cfg_data;
				csb_pkg::REG_KEY_ENABLE:    key_enable_q    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	csb_raster u_raster (
		.clk           (clk),
		.arst_n        (arst_n),
		.advance       (in_valid && in_ready),
		.clear         (cfg_hit),
		.dest_x        (dest_x_q),
		.dest_y        (dest_y_q),
		.sprite_width  (sprite_width_q),
		.sprite_height (sprite_height_q),
		.source_pixel  (source_pixel),
		.coord         (coord)
	);

	csb_write_stage u_write (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.coord         (coord),
		.key_enable    (key_enable_q),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_data    (write_data),
		.end_of_sprite (end_of_sprite)
	);

endmodule

FILE: bench/csb_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csb_checker
// Watches the register port and both item channels of the sprite blitter,
// predicts every framebuffer write candidate and compares it field by field.
// ----------------------------------------------------------------------------
module csb_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [csb_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [csb_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           in_valid,
	input  logic                           in_ready,
	input  logic [csb_pkg::PIXEL_W-1:0]    source_pixel,
	input  logic                           out_valid,
	input  logic                           out_ready,
	input  logic                           write_enable,
	input  logic [csb_pkg::ADDR_W-1:0]     write_address,
	input  logic [csb_pkg::PIXEL_W-1:0]    write_data,
	input  logic                           end_of_sprite,
	output int                             mismatch_count,
	output int                             pending_count
);

	typedef struct packed {
		logic                        we;
		logic [csb_pkg::ADDR_W-1:0]  addr;
		logic [csb_pkg::PIXEL_W-1:0] data;
		logic                        eos;
	} fb_write_t;

	// Mirror of the block's registers and raster counters.
	logic signed [csb_pkg::CFG_DATA_W-1:0] org_x, org_y;
	logic [csb_pkg::CFG_DATA_W-1:0]        spr_w, spr_h;
	logic                                  key_on;
	logic [csb_pkg::COUNT_W-1:0]           col_cnt, row_cnt;

	fb_write_t expected_writes[$];
	int        fail_tally;

	function automatic fb_write_t predict_write(input logic [csb_pkg::PIXEL_W-1:0] pix);
		fb_write_t res;
		int sx, sy;
		logic row_done, sprite_done;
		res = '0;
		if (spr_w == 0 || spr_h == 0) begin
			col_cnt = '0;
			row_cnt = '0;
		end else begin
			sx = int'(org_x) + int'(col_cnt);
			sy = int'(org_y) + int'(row_cnt);
			row_done = (int'(col_cnt) + 1 >= int'(spr_w));
			sprite_done = (int'(row_cnt) + 1 >= int'(spr_h));
			if (sx >= 0 && sx < csb_pkg::SCREEN_WIDTH && sy >= 0 &&
			    sy < csb_pkg::SCREEN_HEIGHT && !(key_on && pix == csb_pkg::KEY_PIXEL)) begin
				res.we = 1'b1;
				res.addr = csb_pkg::ADDR_W'(sx + csb_pkg::SCREEN_WIDTH * sy);
				res.data = pix;
			end
			if (row_done) begin
				col_cnt = '0;
				if (sprite_done) begin
					row_cnt = '0;
					res.eos = 1'b1;
				end else begin
					row_cnt = row_cnt + 1'b1;
				end
			end else begin
				col_cnt = col_cnt + 1'b1;
			end
		end
		return res;
	endfunction

	task automatic compare_field(input string name, input int unsigned expd,
	                             input int unsigned got);
		if (expd != got) begin
			$error("%s: expected %0d, got %0d", name, expd, got);
			fail_tally++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		fb_write_t want;
		logic      known_reg;
		if (!arst_n) begin
			org_x = '0;
			org_y = '0;
			spr_w = '0;
			spr_h = '0;
			key_on = 1'b0;
			col_cnt = '0;
			row_cnt = '0;
			fail_tally = 0;
			expected_writes.delete();
			mismatch_count <= 0;
			pending_count <= 0;
		end else begin
			if (cfg_we) begin
				known_reg = 1'b1;
				case (csb_pkg::cfg_reg_t'(cfg_index))
					csb_pkg::REG_DEST_X:        org_x = cfg_data;
					csb_pkg::REG_DEST_Y:        org_y = cfg_data;
					csb_pkg::REG_SPRITE_WIDTH:  spr_w = cfg_data;
					csb_pkg::REG_SPRITE_HEIGHT: spr_h = cfg_data;
					csb_pkg::REG_KEY_ENABLE:    key_on = cfg_data[0];
					default:                    known_reg = 1'b0;
				endcase
				// A write to a real register restarts the sprite.
				if (known_reg) begin
					col_cnt = '0;
					row_cnt = '0;
				end
			end
			// Results are checked before this edge's input is predicted, so an
			// extra result can never pair up with an item accepted at the same edge.
			if (out_valid && out_ready) begin
				if (expected_writes.size() == 0) begin
					$error("result item with no expected result pending");
					fail_tally++;
				end else begin
					want = expected_writes.pop_front();
					compare_field("write_enable", want.we, write_enable);
					compare_field("write_address", want.addr, write_address);
					compare_field("write_data", want.data, write_data);
					compare_field("end_of_sprite", want.eos, end_of_sprite);
				end
			end
			if (in_valid && in_ready)
				expected_writes.push_back(predict_write(source_pixel));
			mismatch_count <= fail_tally;
			pending_count <= expected_writes.size();
		end
	end

endmodule

FILE: bench/tb_clipped_sprite_blit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_clipped_sprite_blit
// Drives sprite pixels and register settings into the blitter: a directed
// run over clipping edges, color keying, empty and extreme sprites, then
// randomized sprites with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
module tb_clipped_sprite_blit;

	localparam int ITEM_TARGET    = 1850;
	localparam int STALL_LIMIT    = 4000;
	localparam int PRESSURE_PHASE = 6;

	localparam logic [csb_pkg::CFG_IDX_W-1:0] REG_SPARE_FIRST = 3'd5;
	localparam logic [csb_pkg::CFG_IDX_W-1:0] REG_SPARE_LAST  = 3'd7;

	typedef enum {RX_OPEN, RX_MOSTLY, RX_SPARSE, RX_HOLD} rx_mode_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [csb_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [csb_pkg::CFG_DATA_W-1:0] cfg_data;
	logic                           in_valid;
	logic                           in_ready;
	logic [csb_pkg::PIXEL_W-1:0]    source_pixel;
	logic                           out_valid;
	logic                           out_ready;
	logic                           write_enable;
	logic [csb_pkg::ADDR_W-1:0]     write_address;
	logic [csb_pkg::PIXEL_W-1:0]    write_data;
	logic                           end_of_sprite;
	int                             mismatch_count;
	int                             pending_count;

	int       burst_left;
	bit       no_gaps;
	int       items_sent;
	int       idle_cycles;
	rx_mode_t rx_mode;
	int       rx_left;

	clipped_sprite_blit u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.source_pixel (source_pixel),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.write_enable (write_enable),
		.write_address(write_address),
		.write_data   (write_data),
		.end_of_sprite(end_of_sprite)
	);

	csb_checker u_checker (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.source_pixel  (source_pixel),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.write_enable  (write_enable),
		.write_address (write_address),
		.write_data    (write_data),
		.end_of_sprite (end_of_sprite),
		.mismatch_count(mismatch_count),
		.pending_count (pending_count)
	);

	always #6 clk = ~clk;

	// Receiver pattern: stretches of full acceptance, random stalls and
	// solid holds.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode = rx_mode_t'($urandom_range(0, 3));
			rx_left = (rx_mode == RX_HOLD) ? $urandom_range(1, 20) : $urandom_range(8, 80);
		end
		rx_left--;
		case (rx_mode)
			RX_OPEN:   out_ready <= 1'b1;
			RX_MOSTLY: out_ready <= ($urandom_range(0, 3) != 0);
			RX_SPARSE: out_ready <= ($urandom_range(0, 3) == 0);
			default:   out_ready <= 1'b0;
		endcase
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	function automatic logic [csb_pkg::PIXEL_W-1:0] rand_pixel();
		return ($urandom_range(0, 3) == 0) ? csb_pkg::KEY_PIXEL
		                                   : csb_pkg::PIXEL_W'($urandom_range(0, 255));
	endfunction

	// Leaves cfg_we high; the caller lowers it after the last write of a batch.
	task automatic write_reg(input logic [csb_pkg::CFG_IDX_W-1:0] idx,
	                         input logic [csb_pkg::CFG_DATA_W-1:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
	endtask

	task automatic send_pixel(input logic [csb_pkg::PIXEL_W-1:0] pix);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			gap = no_gaps ? 0 : $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		source_pixel <= pix;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Stops the sender and waits until every expected result has been taken.
	task automatic settle();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_count != 0);
	endtask

	initial begin
		int v, r, cnt, phase, cur_w, cur_h;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		source_pixel = '0;
		out_ready = 1'b0;
		burst_left = 0;
		no_gaps = 1'b0;
		items_sent = 0;
		idle_cycles = 0;
		rx_left = 0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// Registers still at reset: an empty sprite never writes.
		send_pixel(8'h00);
		send_pixel(8'hFF);

		// Sprite hanging off the top-left corner with keying on.
		settle();
		write_reg(csb_pkg::REG_DEST_X, -16'sd1);
		write_reg(csb_pkg::REG_DEST_Y, -16'sd1);
		write_reg(csb_pkg::REG_SPRITE_WIDTH, 16'd3);
		write_reg(csb_pkg::REG_SPRITE_HEIGHT, 16'd3);
		write_reg(csb_pkg::REG_KEY_ENABLE, 16'd1);
		cfg_we <= 1'b0;
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'hA5);
		send_pixel(8'h5A);
		send_pixel(8'hFF);
		send_pixel(8'h01);
		send_pixel(8'h80);
		send_pixel(8'h7F);
		send_pixel(8'hFE);

		// Bottom-right corner, keying off; a spare register index written in
		// mid-sprite must not restart the counters.
		settle();
		write_reg(csb_pkg::REG_DEST_X, 16'(csb_pkg::SCREEN_WIDTH - 2));
		write_reg(csb_pkg::REG_DEST_Y, 16'(csb_pkg::SCREEN_HEIGHT - 2));
		write_reg(csb_pkg::REG_KEY_ENABLE, 16'hFFFE);
		cfg_we <= 1'b0;
		send_pixel(8'hFF);
		send_pixel(8'h55);
		send_pixel(8'hAA);
		settle();
		write_reg(REG_SPARE_FIRST, 16'hFFFF);
		cfg_we <= 1'b0;
		send_pixel(8'hFF);
		send_pixel(8'h0F);
		send_pixel(8'hF0);

		// Extreme positions and sizes.
		settle();
		write_reg(csb_pkg::REG_DEST_X, 16'h8000);
		write_reg(csb_pkg::REG_DEST_Y, 16'h7FFF);
		write_reg(csb_pkg::REG_SPRITE_WIDTH, 16'd1);
		write_reg(csb_pkg::REG_SPRITE_HEIGHT, 16'd2);
		cfg_we <= 1'b0;
		send_pixel(8'h33);
		send_pixel(8'hCC);
		settle();
		write_reg(csb_pkg::REG_DEST_X, 16'd0);
		write_reg(csb_pkg::REG_DEST_Y, 16'd0);
		write_reg(csb_pkg::REG_SPRITE_WIDTH, 16'hFFFF);
		write_reg(csb_pkg::REG_SPRITE_HEIGHT, 16'hFFFF);
		cfg_we <= 1'b0;
		send_pixel(8'h12);
		send_pixel(8'hFF);
		settle();
		write_reg(csb_pkg::REG_SPRITE_HEIGHT, 16'd0);
		cfg_we <= 1'b0;
		send_pixel(8'h99);
		cur_w = 16'hFFFF;
		cur_h = 0;

		for (phase = 0; items_sent < ITEM_TARGET; phase++) begin
			settle();
			if ($urandom_range(0, 2) != 0) begin
				v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF)
				                                : $urandom_range(0, 400) - 40;
				write_reg(csb_pkg::REG_DEST_X, v[15:0]);
			end
			if ($urandom_range(0, 2) != 0) begin
				v = ($urandom_range(0, 7) == 0) ? $urandom_range(0, 16'hFFFF)
				                                : $urandom_range(0, 280) - 40;
				write_reg(csb_pkg::REG_DEST_Y, v[15:0]);
			end
			if (phase == 0 || $urandom_range(0, 2) != 0) begin
				r = $urandom_range(0, 11);
				cur_w = (r == 0) ? 0 : (r == 1) ? $urandom_range(0, 16'hFFFF)
				                                : $urandom_range(1, 20);
				write_reg(csb_pkg::REG_SPRITE_WIDTH, cur_w[15:0]);
			end
			if (phase == 0 || $urandom_range(0, 2) != 0) begin
				r = $urandom_range(0, 11);
				cur_h = (r == 0) ? 0 : (r == 1) ? $urandom_range(0, 16'hFFFF)
				                                : $urandom_range(1, 12);
				write_reg(csb_pkg::REG_SPRITE_HEIGHT, cur_h[15:0]);
			end
			if ($urandom_range(0, 2) == 0)
				write_reg(csb_pkg::REG_KEY_ENABLE, 16'($urandom_range(0, 16'hFFFF)));
			if ($urandom_range(0, 5) == 0)
				write_reg(3'($urandom_range(REG_SPARE_LAST, REG_SPARE_FIRST)),
				          16'($urandom_range(0, 16'hFFFF)));
			cfg_we <= 1'b0;
			no_gaps = ($urandom_range(0, 4) == 0);
			// Whole sprites, often with a partial one left for the next phase.
			if (cur_w > 0 && cur_h > 0 && cur_w <= 64 && cur_h <= 64 && cur_w * cur_h <= 240)
				cnt = cur_w * cur_h * $urandom_range(1, 2) + $urandom_range(0, cur_w);
			else
				cnt = $urandom_range(1, 40);
			// The last phase stops at the item target.
			if (cnt > ITEM_TARGET - items_sent)
				cnt = ITEM_TARGET - items_sent;
			for (int i = 0; i < cnt; i++) begin
				if (phase == PRESSURE_PHASE && i == cnt / 2)
					settle();
				send_pixel(rand_pixel());
			end
		end

		settle();
		repeat (4) @(posedge clk);
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
